// ===== rtl/acb_pkg.sv =====
// ----------------------------------------------------------------------------
// acb_pkg: shared types and constants of the adaptive circuit breaker
// Breaker states, register indexes, multiplier limits, cell operations, sequencer states and the rank helper.
// ----------------------------------------------------------------------------
package acb_pkg;

  // Breaker states as reported on circuit_state.
  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_state_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LAT_WARN  = 8'd0;
  localparam logic [7:0] CFG_LAT_CRIT  = 8'd1;
  localparam logic [7:0] CFG_ERR_WARN  = 8'd2;
  localparam logic [7:0] CFG_ERR_CRIT  = 8'd3;
  localparam logic [7:0] CFG_OPEN_DUR  = 8'd4;
  localparam logic [7:0] CFG_TRIP_THR  = 8'd5;
  localparam logic [7:0] CFG_STEP      = 8'd6;
  localparam logic [7:0] CFG_WINDOW    = 8'd7;

  // Multiplier limits, Q1.15 in a signed working width.
  localparam logic signed [18:0] Q_ONE      = 19'sd32768;
  localparam logic signed [18:0] FLOOR_CRIT = 19'sd3277;
  localparam logic signed [18:0] FLOOR_WARN = 19'sd8192;

  // Operation applied to every window cell in the same cycle.
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_SHIFT = 3'd1,
    OP_LOAD  = 3'd2,
    OP_RINIT = 3'd3,
    OP_RANK  = 3'd4,
    OP_PICK  = 3'd5,
    OP_SCAN  = 3'd6
  } cell_op_t;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADMIT,
    S_INSERT,
    S_PRUNE,
    S_RINIT,
    S_RANK,
    S_PICK,
    S_SCAN,
    S_ERR,
    S_ADJ,
    S_DONE
  } seq_state_t;

  // Rank of the 95th percentile, ceil(0.95 * n) - 1, clamped to n - 1.
  // The division by 20 is a shift by two and a reciprocal multiply by 5.
  function automatic logic [15:0] acb_rank(input logic [15:0] n);
    logic [19:0] x;
    logic [31:0] prod;
    logic [15:0] q;
    logic [15:0] r;
    x    = 20'(n) * 20'd19 + 20'd19;
    prod = 32'(x[19:2]) * 32'd52429;
    q    = 16'(prod >> 18);
    r    = q - 16'd1;
    if (r > n - 16'd1) begin
      r = n - 16'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/acb_if.sv =====
// ----------------------------------------------------------------------------
// acb_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface acb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] now_seconds;
  logic [23:0] latency_value;
  logic        failed;

  modport source(output valid, mode, now_seconds, latency_value, failed, input ready);
  modport sink(input valid, mode, now_seconds, latency_value, failed, output ready);
endinterface

interface acb_out_if;
  logic        valid;
  logic        ready;
  logic        blocked;
  logic [1:0]  circuit_state;
  logic [15:0] rate_scale;
  logic [23:0] p95_latency;
  logic [6:0]  window_count;
  logic [6:0]  window_errors;
  logic [15:0] fail_streak;

  modport source(output valid, blocked, circuit_state, rate_scale, p95_latency,
                 window_count, window_errors, fail_streak, input ready);
  modport sink(input valid, blocked, circuit_state, rate_scale, p95_latency,
               window_count, window_errors, fail_streak, output ready);
endinterface

// ===== rtl/acb_cell.sv =====
// ----------------------------------------------------------------------------
// acb_cell: one sample cell of the window chain
// Holds one sample, passes it to the older neighbor on a shift, and counts
// the rank of its latency against values that travel past it.
// ----------------------------------------------------------------------------
module acb_cell #(
  parameter int LAT_BITS = 24,
  parameter int CW       = 7
) (
  input  logic                 clk,
  input  acb_pkg::cell_op_t    op,
  input  logic                 load,
  input  logic                 valid,
  input  logic [CW-1:0]        rank,
  input  logic [31:0]          new_time,
  input  logic [LAT_BITS-1:0]  new_lat,
  input  logic                 new_err,
  input  logic [31:0]          nbr_time,
  input  logic [LAT_BITS-1:0]  nbr_lat,
  input  logic                 nbr_err,
  input  logic [LAT_BITS-1:0]  nbr_mv,
  input  logic                 nbr_mvv,
  output logic [31:0]          time_o,
  output logic [LAT_BITS-1:0]  lat_o,
  output logic                 err_o,
  output logic [LAT_BITS-1:0]  mv_o,
  output logic                 mvv_o
);
  import acb_pkg::*;

  logic [31:0]         time_r;
  logic [LAT_BITS-1:0] lat_r;
  logic                err_r;
  logic [LAT_BITS-1:0] mv_r;
  logic                mvv_r;
  logic [CW-1:0]       less_r;
  logic [CW-1:0]       same_r;
  logic [CW:0]         upper;
  logic                match;

  // This cell holds the wanted rank when it falls inside its run of equals.
  assign upper = {1'b0, less_r} + {1'b0, same_r};
  assign match = valid && (rank >= less_r) && ({1'b0, rank} < upper);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: begin
      end
      OP_SHIFT: begin
        time_r <= nbr_time;
        lat_r  <= nbr_lat;
        err_r  <= nbr_err;
      end
      OP_LOAD: begin
        if (load) begin
          time_r <= new_time;
          lat_r  <= new_lat;
          err_r  <= new_err;
        end
      end
      OP_RINIT: begin
        mv_r   <= lat_r;
        mvv_r  <= valid;
        less_r <= '0;
        same_r <= '0;
      end
      OP_RANK: begin
        if (mvv_r) begin
          if (mv_r < lat_r) begin
            less_r <= less_r + 1'b1;
          end else if (mv_r == lat_r) begin
            same_r <= same_r + 1'b1;
          end
        end
        mv_r  <= nbr_mv;
        mvv_r <= nbr_mvv;
      end
      OP_PICK: begin
        mv_r  <= match ? lat_r : '0;
        mvv_r <= 1'b0;
      end
      OP_SCAN: begin
        mv_r <= nbr_mv;
      end
      default: begin
      end
    endcase
  end

  assign time_o = time_r;
  assign lat_o  = lat_r;
  assign err_o  = err_r;
  assign mv_o   = mv_r;
  assign mvv_o  = mvv_r;

endmodule

// ===== rtl/adaptive_circuit_breaker.sv =====
// An admission check goes from S_ADMIT to S_DONE, which registers its result once the
// result channel is free. A sample goes through S_INSERT, S_PRUNE, S_RINIT, one rank pass
// over the cell chain (S_RANK), S_PICK, one output pass (S_SCAN), S_ERR, S_ADJ, S_DONE.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset (synchronous, rst_n low) empties the window, closes the circuit,
// sets full rate and loads the register defaults.
// ----------------------------------------------------------------------------
// adaptive_circuit_breaker: backend health monitor with rate multiplier
// Window of samples in a chain of cells, breaker state and multiplier steps.
// ----------------------------------------------------------------------------
module adaptive_circuit_breaker #(
  parameter int WINDOW_DEPTH = 64,
  parameter int LATENCY_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  acb_in_if.sink      in_if,
  acb_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_idx,
  input  logic [23:0] cfg_data
);
  import acb_pkg::*;

  localparam int D  = WINDOW_DEPTH;
  localparam int LB = LATENCY_BITS;
  localparam int CW = $clog2(D + 1);
  localparam int PW = CW + 17;

  // Configuration registers.
  logic [23:0] lat_warn_r, lat_crit_r;
  logic [15:0] err_warn_r, err_crit_r, open_dur_r, trip_thr_r, step_r, win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_warn_r <= 24'd5000;
      lat_crit_r <= 24'd15000;
      err_warn_r <= 16'd3277;
      err_crit_r <= 16'd16384;
      open_dur_r <= 16'd30;
      trip_thr_r <= 16'd5;
      step_r     <= 16'd8192;
      win_r      <= 16'd60;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LAT_WARN: lat_warn_r <= cfg_data;
        CFG_LAT_CRIT: lat_crit_r <= cfg_data;
        CFG_ERR_WARN: err_warn_r <= cfg_data[15:0];
        CFG_ERR_CRIT: err_crit_r <= cfg_data[15:0];
        CFG_OPEN_DUR: open_dur_r <= cfg_data[15:0];
        CFG_TRIP_THR: trip_thr_r <= cfg_data[15:0];
        CFG_STEP:     step_r     <= cfg_data[15:0];
        CFG_WINDOW:   win_r      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  seq_state_t  state_r, state_nxt;
  brk_state_t  brk_r;
  logic [31:0] reopen_r;
  logic [15:0] run_r;
  logic [15:0] mult_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] errs_r;
  logic [CW-1:0] cyc_r;
  logic [CW-1:0] rank_r;
  logic [LB-1:0] acc_r;
  logic [LB-1:0] p95_r;
  logic          crit_e_r, warn_e_r;
  logic          blocked_r;
  logic          out_valid_r;

  // Captured input item.
  logic          mode_r;
  logic [31:0]   now_r;
  logic [LB-1:0] lat_r;
  logic          fail_r;

  // Cell chain wiring.
  cell_op_t      cell_op;
  logic [31:0]   c_time [D];
  logic [LB-1:0] c_lat  [D];
  logic          c_err  [D];
  logic [LB-1:0] c_mv   [D];
  logic          c_mvv  [D];

  logic          in_xfer, out_xfer, out_free, full, prune_hit, last_cyc;

  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_if.valid && out_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign full     = (count_r == CW'(D));
  assign last_cyc = (cyc_r == CW'(D - 1));
  assign prune_hit = (count_r != '0) &&
                     (({1'b0, c_time[0]} + 33'(win_r)) < {1'b0, now_r});

  genvar k;
  generate
    for (k = 0; k < D; k++) begin : g_cell
      logic [31:0]   nt;
      logic [LB-1:0] nl;
      logic          ne;
      logic [LB-1:0] nm;
      logic          nv;
      if (k == D - 1) begin : g_last
        // The newest end takes the new sample; the rank lane wraps around.
        assign nt = now_r;
        assign nl = lat_r;
        assign ne = fail_r;
        assign nm = (cell_op == OP_RANK) ? c_mv[0] : '0;
        assign nv = (cell_op == OP_RANK) ? c_mvv[0] : 1'b0;
      end else begin : g_mid
        assign nt = c_time[k+1];
        assign nl = c_lat[k+1];
        assign ne = c_err[k+1];
        assign nm = c_mv[k+1];
        assign nv = c_mvv[k+1];
      end
      acb_cell #(.LAT_BITS(LB), .CW(CW)) u_cell (
        .clk      (clk),
        .op       (cell_op),
        .load     (count_r == CW'(k)),
        .valid    (CW'(k) < count_r),
        .rank     (rank_r),
        .new_time (now_r),
        .new_lat  (lat_r),
        .new_err  (fail_r),
        .nbr_time (nt),
        .nbr_lat  (nl),
        .nbr_err  (ne),
        .nbr_mv   (nm),
        .nbr_mvv  (nv),
        .time_o   (c_time[k]),
        .lat_o    (c_lat[k]),
        .err_o    (c_err[k]),
        .mv_o     (c_mv[k]),
        .mvv_o    (c_mvv[k])
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = in_if.mode ? S_INSERT : S_ADMIT;
      S_ADMIT:  state_nxt = S_DONE;
      S_INSERT: state_nxt = S_PRUNE;
      S_PRUNE:  if (!prune_hit) state_nxt = S_RINIT;
      S_RINIT:  state_nxt = S_RANK;
      S_RANK:   if (last_cyc) state_nxt = S_PICK;
      S_PICK:   state_nxt = S_SCAN;
      S_SCAN:   if (last_cyc) state_nxt = S_ERR;
      S_ERR:    state_nxt = S_ADJ;
      S_ADJ:    state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Cell operation for the current state.
  always_comb begin
    cell_op = OP_HOLD;
    unique case (state_r)
      S_INSERT: cell_op = full ? OP_SHIFT : OP_LOAD;
      S_PRUNE:  cell_op = prune_hit ? OP_SHIFT : OP_HOLD;
      S_RINIT:  cell_op = OP_RINIT;
      S_RANK:   cell_op = OP_RANK;
      S_PICK:   cell_op = OP_PICK;
      S_SCAN:   cell_op = OP_SCAN;
      default:  cell_op = OP_HOLD;
    endcase
  end

  // Error fraction compares, errors * 32768 against threshold * count.
  logic [PW-1:0] e_scaled, tn_crit, tn_warn;
  assign e_scaled = PW'(errs_r) << 15;
  assign tn_crit  = PW'(err_crit_r) * PW'(count_r);
  assign tn_warn  = PW'(err_warn_r) * PW'(count_r);

  // Multiplier step from the window health.
  logic              crit, warn;
  logic signed [18:0] m_s, s_s, m_new;
  always_comb begin
    crit  = crit_e_r || (32'(acc_r) >= 32'(lat_crit_r));
    warn  = warn_e_r || (32'(acc_r) >= 32'(lat_warn_r));
    m_s   = signed'(19'(mult_r));
    s_s   = signed'(19'(step_r));
    m_new = m_s;
    if (crit) begin
      m_new = m_s - s_s;
      if (m_new < FLOOR_CRIT) m_new = FLOOR_CRIT;
    end else if (warn) begin
      m_new = m_s - (s_s >>> 1);
      if (m_new < FLOOR_WARN) m_new = FLOOR_WARN;
    end else if (m_s < Q_ONE) begin
      m_new = m_s + s_s;
      if (m_new > Q_ONE) m_new = Q_ONE;
    end
  end

  // Failure run and trip time.
  logic [15:0] run_inc;
  logic [32:0] trip_sum;
  assign run_inc  = (run_r != 16'hFFFF) ? run_r + 16'd1 : run_r;
  assign trip_sum = {1'b0, now_r} + 33'(open_dur_r);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      brk_r       <= BRK_CLOSED;
      reopen_r    <= '0;
      run_r       <= '0;
      mult_r      <= 16'd32768;
      count_r     <= '0;
      errs_r      <= '0;
      cyc_r       <= '0;
      p95_r       <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mode_r    <= in_if.mode;
            now_r     <= in_if.now_seconds;
            lat_r     <= LB'(in_if.latency_value);
            fail_r    <= in_if.failed;
            blocked_r <= 1'b0;
          end
        end
        S_ADMIT: begin
          if (brk_r == BRK_OPEN) begin
            if (now_r >= reopen_r) brk_r <= BRK_HALF;
            else blocked_r <= 1'b1;
          end
        end
        S_INSERT: begin
          if (full) begin
            errs_r <= errs_r - CW'(c_err[0]) + CW'(fail_r);
          end else begin
            errs_r  <= errs_r + CW'(fail_r);
            count_r <= count_r + 1'b1;
          end
          if (fail_r) begin
            run_r <= run_inc;
            if ((run_inc >= trip_thr_r) && (brk_r != BRK_OPEN)) begin
              brk_r    <= BRK_OPEN;
              reopen_r <= trip_sum[32] ? 32'hFFFF_FFFF : trip_sum[31:0];
              mult_r   <= '0;
            end
          end else begin
            if (brk_r == BRK_HALF) begin
              brk_r  <= BRK_CLOSED;
              mult_r <= step_r;
            end
            run_r <= '0;
          end
        end
        S_PRUNE: begin
          if (prune_hit) begin
            count_r <= count_r - 1'b1;
            errs_r  <= errs_r - CW'(c_err[0]);
          end
        end
        S_RINIT: begin
          rank_r <= CW'(acb_rank(16'(count_r)));
          cyc_r  <= '0;
        end
        S_RANK: begin
          cyc_r <= last_cyc ? '0 : cyc_r + 1'b1;
        end
        S_PICK: begin
          acc_r <= '0;
        end
        S_SCAN: begin
          acc_r <= acc_r | c_mv[0];
          cyc_r <= cyc_r + 1'b1;
        end
        S_ERR: begin
          crit_e_r <= (count_r != '0) && (e_scaled >= tn_crit);
          warn_e_r <= (count_r != '0) && (e_scaled >= tn_warn);
        end
        S_ADJ: begin
          p95_r <= acc_r;
          if (brk_r != BRK_OPEN) mult_r <= 16'(m_new);
        end
        S_DONE: begin
          if (out_free) begin
            out_if.blocked       <= blocked_r && !mode_r;
            out_if.circuit_state <= brk_r;
            out_if.rate_scale    <= mult_r;
            out_if.p95_latency   <= 24'(p95_r);
            out_if.window_count  <= 7'(count_r);
            out_if.window_errors <= 7'(errs_r);
            out_if.fail_streak   <= run_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result valid: set when a result is registered, cleared by its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(D)) else $error("window count above depth");
  a_errs_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    errs_r <= count_r) else $error("error count above window count");
  a_trip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (brk_r != BRK_OPEN) ##1 (brk_r == BRK_OPEN) |-> (mult_r == '0))
    else $error("circuit opened without clearing the multiplier");
  a_open_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADJ) && (brk_r == BRK_OPEN) |=> $stable(mult_r))
    else $error("multiplier stepped while circuit open");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the adaptive circuit breaker
// Drives admission checks and completion samples over the request channel.
// A cycle-free model of the window, breaker and multiplier predicts every
// result, and the result channel is checked field by field. The bench runs
// several register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
  import acb_pkg::*;

  localparam int DEPTH     = 64;
  localparam int CYC_LIMIT = 600000;

  typedef struct {
    logic        mode;
    logic [31:0] now_s;
    logic [23:0] lat_ms;
    logic        failed;
  } request_t;

  typedef struct {
    logic        blocked;
    logic [1:0]  brk;
    logic [15:0] rate;
    logic [23:0] p95;
    logic [6:0]  count;
    logic [6:0]  errors;
    logic [15:0] streak;
  } health_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_idx;
  logic [23:0] cfg_data;

  acb_in_if  req_ch();
  acb_out_if rsp_ch();

  adaptive_circuit_breaker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_ch),
    .out_if  (rsp_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  request_t pending_q[$];
  health_t  health_q[$];
  int errors_seen;
  int cycles = 0;
  int req_xfers;
  int rsp_xfers;
  int trips_seen;
  int blocks_seen;
  int full_seen;

  // Window and breaker state of the prediction.
  logic [31:0] w_time[DEPTH];
  logic [23:0] w_lat[DEPTH];
  logic        w_err[DEPTH];
  int unsigned w_head;
  int unsigned w_cnt;
  brk_state_t  brk_st;
  logic [31:0] reopen_at;
  int unsigned fail_run;
  int          scale;

  // Register copies.
  int unsigned r_lat_warn, r_lat_crit, r_err_warn, r_err_crit;
  int unsigned r_open_dur, r_trip, r_step, r_win;

  function automatic int unsigned window_errors();
    int unsigned e;
    e = 0;
    for (int k = 0; k < w_cnt; k++) begin
      e += w_err[(w_head + k) % DEPTH];
    end
    return e;
  endfunction

  // 95th percentile: sort the window and take rank ceil(0.95 n) - 1.
  function automatic int unsigned window_p95();
    int unsigned vals[DEPTH];
    int unsigned rank;
    int unsigned v;
    int j;
    if (w_cnt == 0) begin
      return 0;
    end
    for (int k = 0; k < w_cnt; k++) begin
      v = w_lat[(w_head + k) % DEPTH];
      j = k - 1;
      while (j >= 0 && vals[j] > v) begin
        vals[j + 1] = vals[j];
        j--;
      end
      vals[j + 1] = v;
    end
    rank = (19 * w_cnt + 19) / 20 - 1;
    if (rank > w_cnt - 1) begin
      rank = w_cnt - 1;
    end
    return vals[rank];
  endfunction

  // Multiplier step from error fraction and p95, frozen while open.
  function automatic void step_scale();
    longint unsigned n, e;
    int unsigned p;
    bit crit, warn;
    n = w_cnt;
    e = window_errors();
    p = window_p95();
    crit = (n != 0 && e * 32768 >= longint'(r_err_crit) * n) || p >= r_lat_crit;
    warn = (n != 0 && e * 32768 >= longint'(r_err_warn) * n) || p >= r_lat_warn;
    if (brk_st == BRK_OPEN) begin
      return;
    end
    if (crit) begin
      scale -= int'(r_step);
      if (scale < 3277) scale = 3277;
    end else if (warn) begin
      scale -= int'(r_step / 2);
      if (scale < 8192) scale = 8192;
    end else if (scale < 32768) begin
      scale += int'(r_step);
      if (scale > 32768) scale = 32768;
    end
  endfunction

  function automatic void store_sample(request_t rq);
    longint unsigned until_t;
    if (w_cnt >= DEPTH) begin
      w_head = (w_head + 1) % DEPTH;
      w_cnt  = DEPTH - 1;
      full_seen++;
    end
    w_time[(w_head + w_cnt) % DEPTH] = rq.now_s;
    w_lat[(w_head + w_cnt) % DEPTH]  = rq.lat_ms;
    w_err[(w_head + w_cnt) % DEPTH]  = rq.failed;
    w_cnt++;
    // Prune aged samples from the oldest end.
    while (w_cnt > 0 &&
           longint'(w_time[w_head]) + longint'(r_win) < longint'(rq.now_s)) begin
      w_head = (w_head + 1) % DEPTH;
      w_cnt--;
    end
    if (rq.failed) begin
      if (fail_run < 65535) fail_run++;
      if (fail_run >= r_trip && brk_st != BRK_OPEN) begin
        until_t   = longint'(rq.now_s) + r_open_dur;
        brk_st    = BRK_OPEN;
        reopen_at = (until_t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : until_t[31:0];
        scale     = 0;
        trips_seen++;
      end
    end else begin
      if (brk_st == BRK_HALF) begin
        brk_st = BRK_CLOSED;
        scale  = int'(r_step);
      end
      fail_run = 0;
    end
    step_scale();
  endfunction

  function automatic health_t predict_health(request_t rq);
    health_t h;
    h.blocked = 1'b0;
    if (!rq.mode) begin
      if (brk_st == BRK_OPEN) begin
        if (rq.now_s >= reopen_at) brk_st = BRK_HALF;
        else h.blocked = 1'b1;
      end
    end else begin
      store_sample(rq);
    end
    if (h.blocked) blocks_seen++;
    h.brk    = brk_st;
    h.rate   = scale[15:0];
    h.p95    = window_p95();
    h.count  = w_cnt;
    h.errors = window_errors();
    h.streak = fail_run;
    return h;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d, expected %0d", rsp_xfers, field, got, want);
    errors_seen++;
  endtask

  // Clock, reset and known values on every input.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = 1'b0;
    req_ch.now_seconds = '0;
    req_ch.latency_value = '0;
    req_ch.failed = 1'b0;
    rsp_ch.ready = 1'b0;
    fork
      forever #2 clk = ~clk;
      begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("adaptive_circuit_breaker regression: fail");
      $finish;
    end
  end

  // Request driver: bursts from the pending queue with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        rq.mode   = req_ch.mode;
        rq.now_s  = req_ch.now_seconds;
        rq.lat_ms = req_ch.latency_value;
        rq.failed = req_ch.failed;
        health_q.insert(health_q.size(), predict_health(rq));
        req_xfers++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          rq = pending_q[0];
          pending_q.delete(0);
          req_ch.valid         <= 1'b1;
          req_ch.mode          <= rq.mode;
          req_ch.now_seconds   <= rq.now_s;
          req_ch.latency_value <= rq.lat_ms;
          req_ch.failed        <= rq.failed;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(12, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(400, 1);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once traffic is going.
  int stall_kind = 0;
  int stall_span = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && req_xfers >= 60) begin
      hold_done = 1;
      hold_left = 3000;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_kind = $urandom_range(2, 0);
        stall_span = $urandom_range(600, 20);
      end
      stall_span--;
      case (stall_kind)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= $urandom_range(1, 0);
        default: rsp_ch.ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  // Result monitor: each transfer against the oldest expectation.
  always @(posedge clk) begin
    health_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_xfers++;
      if (health_q.size() == 0) begin
        $display("MISMATCH result %0d arrived with nothing expected", rsp_xfers);
        errors_seen++;
      end else begin
        want = health_q[0];
        health_q.delete(0);
        if (rsp_ch.blocked !== want.blocked)
          report_mismatch("blocked", rsp_ch.blocked, want.blocked);
        if (rsp_ch.circuit_state !== want.brk)
          report_mismatch("circuit_state", rsp_ch.circuit_state, want.brk);
        if (rsp_ch.rate_scale !== want.rate)
          report_mismatch("rate_scale", rsp_ch.rate_scale, want.rate);
        if (rsp_ch.p95_latency !== want.p95)
          report_mismatch("p95_latency", rsp_ch.p95_latency, want.p95);
        if (rsp_ch.window_count !== want.count)
          report_mismatch("window_count", rsp_ch.window_count, want.count);
        if (rsp_ch.window_errors !== want.errors)
          report_mismatch("window_errors", rsp_ch.window_errors, want.errors);
        if (rsp_ch.fail_streak !== want.streak)
          report_mismatch("fail_streak", rsp_ch.fail_streak, want.streak);
      end
    end
  end

  task automatic queue_request(bit mode, logic [31:0] now_s, logic [23:0] lat, bit failed);
    request_t rq;
    rq.mode = mode;
    rq.now_s = now_s;
    rq.lat_ms = lat;
    rq.failed = failed;
    pending_q.insert(pending_q.size(), rq);
  endtask

  // Registers are only written with nothing in flight.
  task automatic wait_quiet();
    while (pending_q.size() > 0 || health_q.size() > 0 || req_ch.valid) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_LAT_WARN: r_lat_warn = val;
      CFG_LAT_CRIT: r_lat_crit = val;
      CFG_ERR_WARN: r_err_warn = val[15:0];
      CFG_ERR_CRIT: r_err_crit = val[15:0];
      CFG_OPEN_DUR: r_open_dur = val[15:0];
      CFG_TRIP_THR: r_trip     = val[15:0];
      CFG_STEP:     r_step     = val[15:0];
      CFG_WINDOW:   r_win      = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random samples and checks with a drifting clock and occasional jumps.
  task automatic queue_random(int n, int mode1_pct, int fail_pct, ref logic [31:0] now_s);
    logic [23:0] lat;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9, 0))
        0: now_s += $urandom_range(2 * r_win + 2, 0);
        1: now_s = $urandom();
        default: now_s += $urandom_range(2, 0);
      endcase
      case ($urandom_range(5, 0))
        0: lat = $urandom();
        1: lat = ($urandom_range(1, 0) == 0) ? 24'd0 : 24'hFFFFFF;
        default: lat = $urandom_range(20000, 0);
      endcase
      queue_request($urandom_range(99, 0) < mode1_pct, now_s, lat,
                    $urandom_range(99, 0) < fail_pct);
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [31:0] t;
    w_head = 0; w_cnt = 0; brk_st = BRK_CLOSED; reopen_at = 0; fail_run = 0;
    scale = 32768;
    r_lat_warn = 5000; r_lat_crit = 15000; r_err_warn = 3277; r_err_crit = 16384;
    r_open_dur = 30; r_trip = 5; r_step = 8192; r_win = 60;
    errors_seen = 0; req_xfers = 0; rsp_xfers = 0;
    trips_seen = 0; blocks_seen = 0; full_seen = 0;
    @(posedge rst_n);

    // Directed: empty window check, latency extremes, trip, block, half open.
    queue_request(0, 0, 0, 0);
    queue_request(1, 10, 24'd0, 0);
    queue_request(1, 11, 24'hFFFFFF, 0);
    queue_request(1, 12, 24'd14999, 0);
    queue_request(1, 12, 24'd5000, 0);
    for (int i = 0; i < 5; i++) queue_request(1, 100, 24'd100, 1);
    queue_request(0, 110, 0, 0);
    queue_request(1, 111, 24'd50, 0);
    queue_request(1, 112, 24'd50, 1);
    queue_request(0, 130, 0, 0);
    queue_request(0, 131, 0, 0);
    queue_request(1, 132, 24'd10, 0);
    queue_request(1, 133, 24'd10, 0);
    queue_request(1, 500, 24'd10, 0);
    queue_request(0, 32'hFFFF_FFFF, 24'hFFFFFF, 1);
    wait_quiet();

    // Wide window so the ring fills and wraps; no trips.
    write_reg(CFG_WINDOW, 24'hFFFF);
    write_reg(CFG_TRIP_THR, 24'hFFFF);
    write_reg(CFG_LAT_WARN, 24'd9000);
    write_reg(CFG_ERR_CRIT, 24'h8000);
    t = 1000;
    for (int i = 0; i < 70; i++) begin
      queue_request(1, t, $urandom_range(20000, 0), $urandom_range(99, 0) < 30);
      t += $urandom_range(2, 0);
    end
    wait_quiet();

    // Extremes: trip on any failure, zero open time, one-second window.
    write_reg(CFG_LAT_WARN, 24'd0);
    write_reg(CFG_LAT_CRIT, 24'hFFFFFF);
    write_reg(CFG_ERR_WARN, 24'h8000);
    write_reg(CFG_ERR_CRIT, 24'd0);
    write_reg(CFG_OPEN_DUR, 24'd0);
    write_reg(CFG_TRIP_THR, 24'd1);
    write_reg(CFG_STEP, 24'h8000);
    write_reg(CFG_WINDOW, 24'd1);
    queue_random(17, 70, 40, t);
    wait_quiet();

    // Saturating trip time near the top of the clock, zero step.
    write_reg(CFG_LAT_WARN, 24'hFFFFFF);
    write_reg(CFG_LAT_CRIT, 24'h7FFFFF);
    write_reg(CFG_ERR_WARN, 24'h7FFF);
    write_reg(CFG_ERR_CRIT, 24'h5555);
    write_reg(CFG_OPEN_DUR, 24'hFFFF);
    write_reg(CFG_TRIP_THR, 24'd3);
    write_reg(CFG_STEP, 24'd0);
    write_reg(CFG_WINDOW, 24'd300);
    t = 32'hFFFF_FF00;
    queue_random(17, 65, 50, t);
    wait_quiet();

    // Random mid settings.
    write_reg(CFG_LAT_WARN, $urandom_range(12000, 1000));
    write_reg(CFG_LAT_CRIT, $urandom_range(20000, 8000));
    write_reg(CFG_ERR_WARN, $urandom_range(16000, 1));
    write_reg(CFG_ERR_CRIT, $urandom_range(32768, 8000));
    write_reg(CFG_OPEN_DUR, $urandom_range(50, 1));
    write_reg(CFG_TRIP_THR, $urandom_range(6, 2));
    write_reg(CFG_STEP, $urandom_range(12000, 1));
    write_reg(CFG_WINDOW, $urandom_range(100, 5));
    queue_random(17, 75, 35, t);
    wait_quiet();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d results over five register settings",
             req_xfers, rsp_xfers);
    $display("breaker tripped %0d times, refused %0d checks, ring overflowed %0d times",
             trips_seen, blocks_seen, full_seen);
    if (errors_seen == 0 && health_q.size() == 0) begin
      $display("adaptive_circuit_breaker regression: pass");
    end else begin
      $display("adaptive_circuit_breaker regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/acb_pkg.sv
rtl/acb_if.sv
rtl/acb_cell.sv
rtl/adaptive_circuit_breaker.sv
dv/tb.sv
